// File: rtl/bps_pkg.sv
// Shared types, widths and constants of the Blinn-Phong fragment shader.
`default_nettype none
package bps_pkg;

  // field widths
  localparam int unsigned COL_W      = 8;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned NRM_W      = 16;
  localparam int unsigned GAIN_W     = 9;
  localparam int unsigned SHIN_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // normalizer datapath
  localparam int unsigned VEC_W      = 25;   // signed vector component
  localparam int unsigned MAG_W      = 25;   // magnitude of a component
  localparam int unsigned SQ_W       = 50;   // square of a magnitude
  localparam int unsigned RAD_W      = 64;   // radicand |v|^2 * 4096
  localparam int unsigned ROOT_STEPS = 32;   // one root bit per stage
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned QUO_W      = 17;   // quotient bits, one per stage
  localparam int unsigned REM_W      = 49;
  localparam int unsigned FRAC_SHIFT = 20;
  localparam int unsigned UNIT_W     = 18;   // signed Q4.14

  // lighting datapath
  localparam int unsigned DOT_W      = 38;
  localparam int unsigned Q16_W      = 17;
  localparam int unsigned SQR_W      = 34;
  localparam int unsigned SPEC_STEPS = 7;
  localparam int unsigned SGP_W      = 26;
  localparam int unsigned S16_W      = 18;
  localparam int unsigned ASUM_W     = 18;
  localparam int unsigned MIX_W      = 27;
  localparam int unsigned BYTE_T_W   = 11;

  localparam logic signed [VEC_W-1:0] HALF_Z   = 25'sd16384;
  localparam logic [Q16_W-1:0]        UNIT_Q16 = 17'd65536;
  localparam logic [COL_W-1:0]        CHAN_MAX = 8'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHININESS = 3'd5;

  // register reset values
  localparam logic signed [POS_W-1:0] LIGHT_X_RST   = 24'sd2048;
  localparam logic signed [POS_W-1:0] LIGHT_Y_RST   = 24'sd2048;
  localparam logic signed [POS_W-1:0] LIGHT_Z_RST   = 24'sd20480;
  localparam logic [GAIN_W-1:0]       AMBIENT_RST   = 9'd51;
  localparam logic [GAIN_W-1:0]       SPECULAR_RST  = 9'd102;
  localparam logic [SHIN_W-1:0]       SHININESS_RST = 3'd7;

  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef struct packed {
    unit_t x;
    unit_t y;
    unit_t z;
  } uvec_t;

  typedef struct packed {
    logic [COL_W-1:0] r;
    logic [COL_W-1:0] g;
    logic [COL_W-1:0] b;
  } rgb_t;

endpackage
`default_nettype wire

// File: rtl/bps_norm.sv
// Pipelined vector normalizer: squares, bit-per-stage square root, bit-per-stage divide.
`default_nettype none
module bps_norm
  import bps_pkg::*;
#(
  parameter int unsigned SB_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [VEC_W-1:0] v_i [3],
  input  logic [SB_W-1:0]         sb_i,
  output logic                    valid_o,
  output uvec_t                   u_o,
  output logic [SB_W-1:0]         sb_o
);

  // stage A: magnitudes and signs
  logic             va_q;
  logic [MAG_W-1:0] mag_a_q [3];
  logic [2:0]       neg_a_q;
  logic [SB_W-1:0]  sb_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (en_i) va_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        neg_a_q[c] <= v_i[c][VEC_W-1];
        mag_a_q[c] <= v_i[c][VEC_W-1] ? MAG_W'(-v_i[c]) : MAG_W'(v_i[c]);
      end
      sb_a_q <= sb_i;
    end
  end

  // stage B: squares
  logic             vb_q;
  logic [SQ_W-1:0]  sq_b_q  [3];
  logic [MAG_W-1:0] mag_b_q [3];
  logic [2:0]       neg_b_q;
  logic [SB_W-1:0]  sb_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en_i) vb_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        sq_b_q[c]  <= SQ_W'(mag_a_q[c]) * SQ_W'(mag_a_q[c]);
        mag_b_q[c] <= mag_a_q[c];
      end
      neg_b_q <= neg_a_q;
      sb_b_q  <= sb_a_q;
    end
  end

  // square root pipeline; entry 0 is the radicand register
  logic             rv_q   [0:ROOT_STEPS];
  logic [RAD_W-1:0] rx_q   [0:ROOT_STEPS];
  logic [RAD_W-1:0] rr_q   [0:ROOT_STEPS];
  logic [MAG_W-1:0] rmag_q [0:ROOT_STEPS][3];
  logic [2:0]       rneg_q [0:ROOT_STEPS];
  logic [SB_W-1:0]  rsb_q  [0:ROOT_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q[0] <= 1'b0;
    else if (en_i) rv_q[0] <= vb_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0]   <= (RAD_W'(sq_b_q[0]) + RAD_W'(sq_b_q[1]) + RAD_W'(sq_b_q[2])) << 12;
      rr_q[0]   <= '0;
      rmag_q[0] <= mag_b_q;
      rneg_q[0] <= neg_b_q;
      rsb_q[0]  <= sb_b_q;
    end
  end

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * j);
    logic [RAD_W-1:0] trial;
    assign trial = rr_q[j] + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rv_q[j+1] <= 1'b0;
      else if (en_i) rv_q[j+1] <= rv_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rx_q[j] >= trial) begin
          rx_q[j+1] <= rx_q[j] - trial;
          rr_q[j+1] <= (rr_q[j] >> 1) + BIT;
        end else begin
          rx_q[j+1] <= rx_q[j];
          rr_q[j+1] <= rr_q[j] >> 1;
        end
        rmag_q[j+1] <= rmag_q[j];
        rneg_q[j+1] <= rneg_q[j];
        rsb_q[j+1]  <= rsb_q[j];
      end
    end
  end

  // divide pipeline: each component over the length, one quotient bit a stage
  logic             dv_q   [QUO_W];
  logic [LEN_W-1:0] dlen_q [QUO_W];
  logic [REM_W-1:0] drem_q [QUO_W][3];
  logic [QUO_W-1:0] dq_q   [QUO_W][3];
  logic [2:0]       dneg_q [QUO_W];
  logic [SB_W-1:0]  dsb_q  [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    localparam int unsigned QB = QUO_W - 1 - i;
    logic             vin;
    logic [LEN_W-1:0] lin;
    logic [REM_W-1:0] rin [3];
    logic [QUO_W-1:0] qin [3];
    logic [2:0]       nin;
    logic [SB_W-1:0]  sbin;
    logic [REM_W-1:0] dsh;

    if (i == 0) begin : g_first
      assign vin  = rv_q[ROOT_STEPS];
      assign lin  = rr_q[ROOT_STEPS][LEN_W-1:0];
      assign nin  = rneg_q[ROOT_STEPS];
      assign sbin = rsb_q[ROOT_STEPS];
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign rin[c] = REM_W'(rmag_q[ROOT_STEPS][c]) << FRAC_SHIFT;
        assign qin[c] = '0;
      end
    end else begin : g_next
      assign vin  = dv_q[i-1];
      assign lin  = dlen_q[i-1];
      assign nin  = dneg_q[i-1];
      assign sbin = dsb_q[i-1];
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign rin[c] = drem_q[i-1][c];
        assign qin[c] = dq_q[i-1][c];
      end
    end

    assign dsh = REM_W'(lin) << QB;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[i] <= 1'b0;
      else if (en_i) dv_q[i] <= vin;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int c = 0; c < 3; c++) begin
          // a zero length leaves the quotient at zero
          if (lin != '0 && rin[c] >= dsh) begin
            drem_q[i][c] <= rin[c] - dsh;
            dq_q[i][c]   <= qin[c] | (QUO_W'(1) << QB);
          end else begin
            drem_q[i][c] <= rin[c];
            dq_q[i][c]   <= qin[c];
          end
        end
        dlen_q[i] <= lin;
        dneg_q[i] <= nin;
        dsb_q[i]  <= sbin;
      end
    end
  end

  // output: restore signs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= dv_q[QUO_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_o.x <= dneg_q[QUO_W-1][0] ? -unit_t'(dq_q[QUO_W-1][0]) : unit_t'(dq_q[QUO_W-1][0]);
      u_o.y <= dneg_q[QUO_W-1][1] ? -unit_t'(dq_q[QUO_W-1][1]) : unit_t'(dq_q[QUO_W-1][1]);
      u_o.z <= dneg_q[QUO_W-1][2] ? -unit_t'(dq_q[QUO_W-1][2]) : unit_t'(dq_q[QUO_W-1][2]);
      sb_o  <= dsb_q[QUO_W-1];
    end
  end

endmodule
`default_nettype wire

// File: rtl/bps_shade.sv
// Lighting pipeline: dot products, specular power, gains and channel mix.
`default_nettype none
module bps_shade
  import bps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  rgb_t              rgb_i,
  input  uvec_t             n_i,
  input  uvec_t             l_i,
  input  uvec_t             h_i,
  input  logic [GAIN_W-1:0] ambient_gain_i,
  input  logic [GAIN_W-1:0] specular_gain_i,
  input  logic [SHIN_W-1:0] shininess_log2_i,
  output logic              valid_o,
  output rgb_t              rgb_o
);

  function automatic logic [Q16_W-1:0] dot_q16(input logic signed [DOT_W-1:0] d);
    logic [DOT_W-1:0] r;
    r = DOT_W'(d) >> 12;
    if (d <= 0) return '0;
    if (r > DOT_W'(UNIT_Q16)) return UNIT_Q16;
    return Q16_W'(r);
  endfunction

  // stage P: component products
  logic                          vp_q;
  logic signed [2*UNIT_W-1:0]    pl_q [3];
  logic signed [2*UNIT_W-1:0]    ph_q [3];
  rgb_t                          rgb_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vp_q <= 1'b0;
    else if (en_i) vp_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q[0] <= n_i.x * l_i.x;
      pl_q[1] <= n_i.y * l_i.y;
      pl_q[2] <= n_i.z * l_i.z;
      ph_q[0] <= n_i.x * h_i.x;
      ph_q[1] <= n_i.y * h_i.y;
      ph_q[2] <= n_i.z * h_i.z;
      rgb_p_q <= rgb_i;
    end
  end

  // stage D (entry 0 of the power chain): sums and clamps
  logic             sv_q   [0:SPEC_STEPS];
  logic [Q16_W-1:0] sp_q   [0:SPEC_STEPS];
  logic [Q16_W-1:0] sd_q   [0:SPEC_STEPS];
  rgb_t             srgb_q [0:SPEC_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (en_i) sv_q[0] <= vp_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0]   <= dot_q16(DOT_W'(pl_q[0]) + DOT_W'(pl_q[1]) + DOT_W'(pl_q[2]));
      sp_q[0]   <= dot_q16(DOT_W'(ph_q[0]) + DOT_W'(ph_q[1]) + DOT_W'(ph_q[2]));
      srgb_q[0] <= rgb_p_q;
    end
  end

  // repeated squaring, one square a stage; pass through past the exponent
  for (genvar k = 0; k < SPEC_STEPS; k++) begin : g_pow
    logic [SQR_W-1:0] sqr;
    assign sqr = SQR_W'(sp_q[k]) * SQR_W'(sp_q[k]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else if (en_i) sv_q[k+1] <= sv_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sp_q[k+1]   <= (shininess_log2_i > SHIN_W'(k)) ? Q16_W'(sqr >> 16) : sp_q[k];
        sd_q[k+1]   <= sd_q[k];
        srgb_q[k+1] <= srgb_q[k];
      end
    end
  end

  // stage G: gains
  logic              vg_q;
  logic [S16_W-1:0]  s16_q;
  logic [ASUM_W-1:0] asum_q;
  rgb_t              rgb_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vg_q <= 1'b0;
    else if (en_i) vg_q <= sv_q[SPEC_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s16_q   <= S16_W'((SGP_W'(sp_q[SPEC_STEPS]) * SGP_W'(specular_gain_i)) >> 8);
      asum_q  <= ASUM_W'({ambient_gain_i, 8'b0}) + ASUM_W'(sd_q[SPEC_STEPS]);
      rgb_g_q <= srgb_q[SPEC_STEPS];
    end
  end

  // stage M: channel products
  logic             vm_q;
  logic [MIX_W-1:0] prod_q [3];
  logic [MIX_W-1:0] spec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else if (en_i) vm_q <= vg_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q[0] <= MIX_W'(rgb_g_q.r) * MIX_W'(asum_q);
      prod_q[1] <= MIX_W'(rgb_g_q.g) * MIX_W'(asum_q);
      prod_q[2] <= MIX_W'(rgb_g_q.b) * MIX_W'(asum_q);
      spec_q    <= MIX_W'(s16_q) * MIX_W'(CHAN_MAX);
    end
  end

  // stage O: add, scale, clamp into the output register
  logic [BYTE_T_W-1:0] t [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t[c] = BYTE_T_W'((prod_q[c] + spec_q) >> 16);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= vm_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rgb_o.r <= (t[0] > BYTE_T_W'(CHAN_MAX)) ? CHAN_MAX : t[0][COL_W-1:0];
      rgb_o.g <= (t[1] > BYTE_T_W'(CHAN_MAX)) ? CHAN_MAX : t[1][COL_W-1:0];
      rgb_o.b <= (t[2] > BYTE_T_W'(CHAN_MAX)) ? CHAN_MAX : t[2][COL_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/blinn_phong_fragment_shader_unit.sv
// Top level of the Blinn-Phong fragment shader: config registers and the pipeline chain.
//
// Takes one fragment per cycle while no finished pixel is stalled on the
// output and gives one shaded pixel per fragment, in order. The pipeline is
// three normalizers in a row (normal, light vector, halfway vector), each 53
// stages deep because its square root and its divide resolve one bit per stage,
// and 12 stages of lighting math behind them. The whole pipeline advances
// together: it holds while a finished pixel waits on the output, and takes a
// new fragment in the same cycle that the waiting pixel is taken.
// Configuration writes are always ready and act at once; write them only
// while no fragment is in flight.
`default_nettype none
module blinn_phong_fragment_shader_unit
  import bps_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [COL_W-1:0]        tex_red_i,
  input  logic [COL_W-1:0]        tex_green_i,
  input  logic [COL_W-1:0]        tex_blue_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic signed [NRM_W-1:0] normal_x_i,
  input  logic signed [NRM_W-1:0] normal_y_i,
  input  logic signed [NRM_W-1:0] normal_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [COL_W-1:0]        out_red_o,
  output logic [COL_W-1:0]        out_green_o,
  output logic [COL_W-1:0]        out_blue_o
);

  typedef struct packed {
    rgb_t                    rgb;
    logic signed [VEC_W-1:0] lx;
    logic signed [VEC_W-1:0] ly;
    logic signed [VEC_W-1:0] lz;
  } sb_n_t;

  typedef struct packed {
    rgb_t  rgb;
    uvec_t n;
  } sb_l_t;

  typedef struct packed {
    rgb_t  rgb;
    uvec_t n;
    uvec_t l;
  } sb_h_t;

  // configuration registers
  logic signed [POS_W-1:0] light_x_q, light_y_q, light_z_q;
  logic [GAIN_W-1:0]       ambient_gain_q, specular_gain_q;
  logic [SHIN_W-1:0]       shininess_log2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q        <= LIGHT_X_RST;
      light_y_q        <= LIGHT_Y_RST;
      light_z_q        <= LIGHT_Z_RST;
      ambient_gain_q   <= AMBIENT_RST;
      specular_gain_q  <= SPECULAR_RST;
      shininess_log2_q <= SHININESS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LIGHT_X:   light_x_q        <= cfg_data_i;
        CFG_LIGHT_Y:   light_y_q        <= cfg_data_i;
        CFG_LIGHT_Z:   light_z_q        <= cfg_data_i;
        CFG_AMBIENT:   ambient_gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_SPECULAR:  specular_gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_SHININESS: shininess_log2_q <= cfg_data_i[SHIN_W-1:0];
        default: ;
      endcase
    end
  end

  // advance every stage together unless the output beat is stalled
  logic en;
  logic out_valid;
  assign en          = !out_valid || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid;

  // normal, with the light vector riding along
  logic signed [VEC_W-1:0] v_n [3];
  sb_n_t                   sb_n_in, sb_n_out;
  logic                    vld_n;
  uvec_t                   u_n;

  assign v_n[0] = VEC_W'(normal_x_i);
  assign v_n[1] = VEC_W'(normal_y_i);
  assign v_n[2] = VEC_W'(normal_z_i);

  assign sb_n_in.rgb = '{r: tex_red_i, g: tex_green_i, b: tex_blue_i};
  assign sb_n_in.lx  = VEC_W'(light_x_q) - VEC_W'(pos_x_i);
  assign sb_n_in.ly  = VEC_W'(light_y_q) - VEC_W'(pos_y_i);
  assign sb_n_in.lz  = VEC_W'(light_z_q) - VEC_W'(pos_z_i);

  bps_norm #(.SB_W($bits(sb_n_t))) u_norm_n (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .v_i     (v_n),
    .sb_i    (sb_n_in),
    .valid_o (vld_n),
    .u_o     (u_n),
    .sb_o    (sb_n_out)
  );

  // light vector
  logic signed [VEC_W-1:0] v_l [3];
  sb_l_t                   sb_l_in, sb_l_out;
  logic                    vld_l;
  uvec_t                   u_l;

  assign v_l[0]      = sb_n_out.lx;
  assign v_l[1]      = sb_n_out.ly;
  assign v_l[2]      = sb_n_out.lz;
  assign sb_l_in.rgb = sb_n_out.rgb;
  assign sb_l_in.n   = u_n;

  bps_norm #(.SB_W($bits(sb_l_t))) u_norm_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_n),
    .v_i     (v_l),
    .sb_i    (sb_l_in),
    .valid_o (vld_l),
    .u_o     (u_l),
    .sb_o    (sb_l_out)
  );

  // halfway vector from L plus the fixed view direction
  logic signed [VEC_W-1:0] v_h [3];
  sb_h_t                   sb_h_in, sb_h_out;
  logic                    vld_h;
  uvec_t                   u_h;

  assign v_h[0]      = VEC_W'(u_l.x);
  assign v_h[1]      = VEC_W'(u_l.y);
  assign v_h[2]      = VEC_W'(u_l.z) + HALF_Z;
  assign sb_h_in.rgb = sb_l_out.rgb;
  assign sb_h_in.n   = sb_l_out.n;
  assign sb_h_in.l   = u_l;

  bps_norm #(.SB_W($bits(sb_h_t))) u_norm_h (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_l),
    .v_i     (v_h),
    .sb_i    (sb_h_in),
    .valid_o (vld_h),
    .u_o     (u_h),
    .sb_o    (sb_h_out)
  );

  rgb_t rgb_out;

  bps_shade u_shade (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (vld_h),
    .rgb_i            (sb_h_out.rgb),
    .n_i              (sb_h_out.n),
    .l_i              (sb_h_out.l),
    .h_i              (u_h),
    .ambient_gain_i   (ambient_gain_q),
    .specular_gain_i  (specular_gain_q),
    .shininess_log2_i (shininess_log2_q),
    .valid_o          (out_valid),
    .rgb_o            (rgb_out)
  );

  assign out_red_o   = rgb_out.r;
  assign out_green_o = rgb_out.g;
  assign out_blue_o  = rgb_out.b;

endmodule
`default_nettype wire
